/* sv/vcrp_pkg.sv */
// ----------------------------------------------------------------------------
// vcrp_pkg
// Shared types, codes and helpers of the video controller register port.
// ----------------------------------------------------------------------------
`default_nettype none

package vcrp_pkg;

    localparam int VIDEO_WORDS = 32768;
    localparam int VADDR_W     = $clog2(VIDEO_WORDS);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RAISE = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam logic [4:0] SEL_MAWR  = 5'h00;
    localparam logic [4:0] SEL_MARR  = 5'h01;
    localparam logic [4:0] SEL_VRW   = 5'h02;
    localparam logic [4:0] SEL_CR    = 5'h05;
    localparam logic [4:0] SEL_RCR   = 5'h06;
    localparam logic [4:0] SEL_BXR   = 5'h07;
    localparam logic [4:0] SEL_BYR   = 5'h08;
    localparam logic [4:0] SEL_MWR   = 5'h09;
    localparam logic [4:0] SEL_HSR   = 5'h0A;
    localparam logic [4:0] SEL_HDR   = 5'h0B;
    localparam logic [4:0] SEL_VPR   = 5'h0C;
    localparam logic [4:0] SEL_VDW   = 5'h0D;
    localparam logic [4:0] SEL_VCR   = 5'h0E;
    localparam logic [4:0] SEL_DCR   = 5'h0F;
    localparam logic [4:0] SEL_SOUR  = 5'h10;
    localparam logic [4:0] SEL_DESR  = 5'h11;
    localparam logic [4:0] SEL_LENR  = 5'h12;
    localparam logic [4:0] SEL_DVSSR = 5'h13;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [5:0] pending_now;
        logic       vram_dma_start;
        logic       satb_dma_start;
    } result_t;

    function automatic logic [15:0] put_byte(logic [15:0] word, logic hi, logic [7:0] b);
        logic [15:0] r;
        r = hi ? {b, word[7:0]} : {word[15:8], b};
        return r;
    endfunction

    function automatic logic [7:0] step_of(logic [1:0] code);
        logic [7:0] s;
        case (code)
            2'd0:    s = 8'h01;
            2'd1:    s = 8'h20;
            2'd2:    s = 8'h40;
            default: s = 8'h80;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* sv/vcrp_ram.sv */
// ----------------------------------------------------------------------------
// vcrp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vcrp_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/video_controller_register_port.sv */
// ----------------------------------------------------------------------------
// video_controller_register_port
// Host register port of a video display controller with video memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one host access per word: bus read or write, flag raise, no-op.
//   m_* returns one result word per input word, in order: read byte,
//   pending flags after the access, and the two DMA start pulses.
//   A result is registered into the output buffer as its input is accepted.
//   Throughput: one word per cycle while s_ready is high. An access that
//   refetches the read latch (data write with select 1, data-port high-byte
//   read with select 2) then drops s_ready while video memory refills it.
//   A two-word output buffer lets input flow while m_ready is low; when
//   both entries are full s_ready drops until the receiver takes a word.
//   Reset clears all registers and empties the output buffer; video memory
//   content is undefined until written and gets no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module video_controller_register_port (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_opcode,
    input  wire logic [1:0] s_bus_offset,
    input  wire logic [7:0] s_write_byte,
    input  wire logic [5:0] s_raise_flags,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_read_byte,
    output logic [5:0]      m_pending_now,
    output logic            m_vram_dma_start,
    output logic            m_satb_dma_start
);

    localparam int AW = vcrp_pkg::VADDR_W;

    logic [4:0]  register_select_reg, register_select_next;
    logic [15:0] write_address_reg, write_address_next;
    logic [15:0] read_address_reg, read_address_next;
    logic [15:0] read_latch_reg;
    logic [15:0] write_latch_reg, write_latch_next;
    logic [7:0]  address_step_reg, address_step_next;
    logic [5:0]  pending_flags_reg, pending_flags_next;
    logic [5:0]  interrupt_enables_reg, interrupt_enables_next;
    logic [7:0]  control_bits_reg, control_bits_next;
    logic [63:0] scroll_and_line_reg, scroll_and_line_next;
    logic [7:0]  memory_width_fields_reg, memory_width_fields_next;
    logic [55:0] timing_fields_reg, timing_fields_next;
    logic [63:0] dma_registers_reg, dma_registers_next;
    logic [2:0]  dma_modes_reg, dma_modes_next;
    logic        fetch_pending_reg;

    vcrp_pkg::result_t buf0_reg, buf1_reg, res;
    logic [1:0]        count_reg;

    logic        push, pop, hi, dport, fetch, mem_we;
    logic [15:0] mem_wdata, mem_rdata;
    logic [15:0] w;
    logic [7:0]  d;

    assign s_ready = !fetch_pending_reg && (count_reg != 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign hi      = s_bus_offset[0];
    assign dport   = s_bus_offset[1];
    assign d       = s_write_byte;

    assign m_read_byte      = buf0_reg.read_byte;
    assign m_pending_now    = buf0_reg.pending_now;
    assign m_vram_dma_start = buf0_reg.vram_dma_start;
    assign m_satb_dma_start = buf0_reg.satb_dma_start;

    always_comb begin
        register_select_next     = register_select_reg;
        write_address_next       = write_address_reg;
        read_address_next        = read_address_reg;
        write_latch_next         = write_latch_reg;
        address_step_next        = address_step_reg;
        pending_flags_next       = pending_flags_reg;
        interrupt_enables_next   = interrupt_enables_reg;
        control_bits_next        = control_bits_reg;
        scroll_and_line_next     = scroll_and_line_reg;
        memory_width_fields_next = memory_width_fields_reg;
        timing_fields_next       = timing_fields_reg;
        dma_registers_next       = dma_registers_reg;
        dma_modes_next           = dma_modes_reg;
        res                      = '0;
        fetch                    = 1'b0;
        mem_we                   = 1'b0;
        w                        = '0;
        mem_wdata                = vcrp_pkg::put_byte(write_latch_reg, 1'b1, d);
        if (push) begin
            case (vcrp_pkg::opcode_t'(s_opcode))
                vcrp_pkg::OP_READ: begin
                    if (!dport) begin
                        if (!hi) begin
                            res.read_byte      = {2'b00, pending_flags_reg};
                            pending_flags_next = '0;
                        end
                    end else if (register_select_reg == vcrp_pkg::SEL_VRW) begin
                        res.read_byte = hi ? read_latch_reg[15:8] : read_latch_reg[7:0];
                        if (hi) begin
                            read_address_next = read_address_reg + {8'h00, address_step_reg};
                            fetch             = 1'b1;
                        end
                    end
                end
                vcrp_pkg::OP_WRITE: begin
                    if (!dport) begin
                        if (!hi) begin
                            register_select_next = d[4:0];
                        end
                    end else begin
                        case (register_select_reg)
                            vcrp_pkg::SEL_MAWR: begin
                                write_address_next = vcrp_pkg::put_byte(write_address_reg, hi, d);
                            end
                            vcrp_pkg::SEL_MARR: begin
                                read_address_next = vcrp_pkg::put_byte(read_address_reg, hi, d);
                                fetch             = 1'b1;
                            end
                            vcrp_pkg::SEL_VRW: begin
                                write_latch_next = vcrp_pkg::put_byte(write_latch_reg, hi, d);
                                if (hi) begin
                                    mem_we             = 1'b1;
                                    write_address_next = write_address_reg
                                                       + {8'h00, address_step_reg};
                                end
                            end
                            vcrp_pkg::SEL_CR: begin
                                if (!hi) begin
                                    interrupt_enables_next[3:0] = d[3:0];
                                    control_bits_next[3:0]      = d[7:4];
                                    control_bits_next[7]        = 1'b0;
                                end else begin
                                    control_bits_next[6:4] = d[2:0];
                                    control_bits_next[7]   = 1'b0;
                                    address_step_next      = vcrp_pkg::step_of(d[4:3]);
                                end
                            end
                            vcrp_pkg::SEL_RCR: begin
                                scroll_and_line_next[15:0] =
                                    vcrp_pkg::put_byte(scroll_and_line_reg[15:0], hi, d);
                            end
                            vcrp_pkg::SEL_BXR: begin
                                scroll_and_line_next[31:16] =
                                    vcrp_pkg::put_byte(scroll_and_line_reg[31:16], hi, d);
                            end
                            vcrp_pkg::SEL_BYR: begin
                                w = vcrp_pkg::put_byte(scroll_and_line_reg[47:32], hi, d);
                                scroll_and_line_next[47:32] = w;
                                scroll_and_line_next[63:48] = w;
                            end
                            vcrp_pkg::SEL_MWR: begin
                                if (!hi) begin
                                    memory_width_fields_next = d;
                                end
                            end
                            vcrp_pkg::SEL_HSR: begin
                                if (!hi) timing_fields_next[4:0] = d[4:0];
                                else     timing_fields_next[11:5] = d[6:0];
                            end
                            vcrp_pkg::SEL_HDR: begin
                                if (!hi) timing_fields_next[18:12] = d[6:0];
                                else     timing_fields_next[25:19] = d[6:0];
                            end
                            vcrp_pkg::SEL_VPR: begin
                                if (!hi) timing_fields_next[30:26] = d[4:0];
                                else     timing_fields_next[38:31] = d;
                            end
                            vcrp_pkg::SEL_VDW: begin
                                if (!hi) timing_fields_next[46:39] = d;
                                else     timing_fields_next[47] = d[0];
                            end
                            vcrp_pkg::SEL_VCR: begin
                                if (!hi) begin
                                    timing_fields_next[55:48] = d;
                                end
                            end
                            vcrp_pkg::SEL_DCR: begin
                                if (!hi) begin
                                    interrupt_enables_next[5] = 1'b0;
                                    interrupt_enables_next[4] = d[0];
                                    interrupt_enables_next[3] = interrupt_enables_reg[3] | d[1];
                                    dma_modes_next            = d[4:2];
                                end
                            end
                            vcrp_pkg::SEL_SOUR: begin
                                dma_registers_next[15:0] =
                                    vcrp_pkg::put_byte(dma_registers_reg[15:0], hi, d);
                            end
                            vcrp_pkg::SEL_DESR: begin
                                dma_registers_next[31:16] =
                                    vcrp_pkg::put_byte(dma_registers_reg[31:16], hi, d);
                            end
                            vcrp_pkg::SEL_LENR: begin
                                dma_registers_next[47:32] =
                                    vcrp_pkg::put_byte(dma_registers_reg[47:32], hi, d);
                                res.vram_dma_start = hi;
                            end
                            vcrp_pkg::SEL_DVSSR: begin
                                dma_registers_next[63:48] =
                                    vcrp_pkg::put_byte(dma_registers_reg[63:48], hi, d);
                                res.satb_dma_start = hi;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                vcrp_pkg::OP_RAISE: begin
                    pending_flags_next = pending_flags_reg | s_raise_flags;
                end
                default: begin
                end
            endcase
        end
        res.pending_now = pending_flags_next;
    end

    vcrp_ram #(
        .DEPTH (vcrp_pkg::VIDEO_WORDS),
        .WIDTH (16)
    ) u_vram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (write_address_reg[AW-1:0]),
        .wdata (mem_wdata),
        .re    (fetch),
        .raddr (read_address_next[AW-1:0]),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            register_select_reg     <= '0;
            write_address_reg       <= '0;
            read_address_reg        <= '0;
            read_latch_reg          <= '0;
            write_latch_reg         <= '0;
            address_step_reg        <= 8'h01;
            pending_flags_reg       <= '0;
            interrupt_enables_reg   <= '0;
            control_bits_reg        <= '0;
            scroll_and_line_reg     <= '0;
            memory_width_fields_reg <= '0;
            timing_fields_reg       <= '0;
            dma_registers_reg       <= '0;
            dma_modes_reg           <= '0;
            fetch_pending_reg       <= 1'b0;
        end else begin
            register_select_reg     <= register_select_next;
            write_address_reg       <= write_address_next;
            read_address_reg        <= read_address_next;
            write_latch_reg         <= write_latch_next;
            address_step_reg        <= address_step_next;
            pending_flags_reg       <= pending_flags_next;
            interrupt_enables_reg   <= interrupt_enables_next;
            control_bits_reg        <= control_bits_next;
            scroll_and_line_reg     <= scroll_and_line_next;
            memory_width_fields_reg <= memory_width_fields_next;
            timing_fields_reg       <= timing_fields_next;
            dma_registers_reg       <= dma_registers_next;
            dma_modes_reg           <= dma_modes_next;
            fetch_pending_reg       <= fetch;
            if (fetch_pending_reg) begin
                read_latch_reg <= mem_rdata;
            end
        end
    end

    // two-word output buffer, buf0 is the head
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            case ({push, pop})
                2'b10: count_reg <= count_reg + 2'd1;
                2'b01: count_reg <= count_reg - 2'd1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case ({push, pop})
            2'b10: begin
                if (count_reg == 2'd0) buf0_reg <= res;
                else                   buf1_reg <= res;
            end
            2'b01: begin
                buf0_reg <= buf1_reg;
            end
            2'b11: begin
                if (count_reg == 2'd1) begin
                    buf0_reg <= res;
                end else begin
                    buf0_reg <= buf1_reg;
                    buf1_reg <= res;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/vcrp_checker.sv */
// ----------------------------------------------------------------------------
// vcrp_checker
// Port-level assertions for the video controller register port.
// ----------------------------------------------------------------------------
`default_nettype none

module vcrp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [1:0] s_opcode,
    input wire logic [1:0] s_bus_offset,
    input wire logic [7:0] s_write_byte,
    input wire logic [5:0] s_raise_flags,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_read_byte,
    input wire logic [5:0] m_pending_now,
    input wire logic       m_vram_dma_start,
    input wire logic       m_satb_dma_start
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_byte)
            && $stable(m_pending_now) && $stable(m_vram_dma_start)
            && $stable(m_satb_dma_start))
        else $error("stalled result word changed");

    a_one_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_vram_dma_start && m_satb_dma_start))
        else $error("both DMA starts in one word");

    a_pulse_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_vram_dma_start || m_satb_dma_start) |-> m_read_byte == 8'h00)
        else $error("DMA start word carries read data");

endmodule

bind video_controller_register_port vcrp_checker u_vcrp_checker (.*);

`default_nettype wire

/* test/register_port_checker.sv */
// ----------------------------------------------------------------------------
// register_port_checker
// Watches both channels of the video controller register port. It predicts
// the result word of every accepted host word and compares the fields of
// each returned word, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module register_port_checker
    import vcrp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [1:0]        s_bus_offset,
    input  logic [7:0]        s_write_byte,
    input  logic [5:0]        s_raise_flags,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [7:0]        m_read_byte,
    input  logic [5:0]        m_pending_now,
    input  logic              m_vram_dma_start,
    input  logic              m_satb_dma_start,
    output int unsigned       backlog,
    output int unsigned       fail_count
);

    // only the state needed to predict a result word is kept
    logic [4:0]  reg_sel;
    logic [15:0] wr_addr;
    logic [15:0] rd_addr;
    logic [15:0] rd_latch;
    logic [15:0] wr_latch;
    logic [7:0]  addr_step;
    logic [5:0]  irq_pending;
    logic [15:0] vram [VIDEO_WORDS];

    result_t     expected_q[$];
    int unsigned mismatches = 0;

    function automatic logic [15:0] with_byte(logic [15:0] w, logic hi, logic [7:0] b);
        return hi ? {b, w[7:0]} : {w[15:8], b};
    endfunction

    function automatic result_t host_result(opcode_t op, logic [1:0] off, logic [7:0] d,
                                            logic [5:0] raise);
        result_t r;
        logic    hi;
        hi = off[0];
        r  = '0;
        case (op)
            OP_READ: begin
                if (!off[1]) begin
                    if (!hi) begin
                        r.read_byte = {2'b00, irq_pending};
                        irq_pending = '0;
                    end
                end else if (reg_sel == SEL_VRW) begin
                    r.read_byte = hi ? rd_latch[15:8] : rd_latch[7:0];
                    if (hi) begin
                        rd_addr  = rd_addr + addr_step;
                        rd_latch = vram[rd_addr % VIDEO_WORDS];
                    end
                end
            end
            OP_WRITE: begin
                if (!off[1]) begin
                    if (!hi) reg_sel = d[4:0];
                end else begin
                    case (reg_sel)
                        SEL_MAWR: wr_addr = with_byte(wr_addr, hi, d);
                        SEL_MARR: begin
                            rd_addr  = with_byte(rd_addr, hi, d);
                            rd_latch = vram[rd_addr % VIDEO_WORDS];
                        end
                        SEL_VRW: begin
                            wr_latch = with_byte(wr_latch, hi, d);
                            if (hi) begin
                                vram[wr_addr % VIDEO_WORDS] = wr_latch;
                                wr_addr = wr_addr + addr_step;
                            end
                        end
                        SEL_CR: begin
                            if (hi) addr_step = (d[4:3] == 2'd0) ? 8'h01 : 8'h20 << (d[4:3] - 2'd1);
                        end
                        SEL_LENR:  r.vram_dma_start = hi;
                        SEL_DVSSR: r.satb_dma_start = hi;
                        default: ;
                    endcase
                end
            end
            OP_RAISE: irq_pending = irq_pending | raise;
            default: ;
        endcase
        r.pending_now = irq_pending;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            reg_sel     = '0;
            wr_addr     = '0;
            rd_addr     = '0;
            rd_latch    = '0;
            wr_latch    = '0;
            addr_step   = 8'h01;
            irq_pending = '0;
            expected_q.delete();
        end else begin
            if (s_valid && s_ready)
                expected_q.push_back(host_result(opcode_t'(s_opcode), s_bus_offset,
                                                 s_write_byte, s_raise_flags));
            if (m_valid && m_ready) begin
                got = {m_read_byte, m_pending_now, m_vram_dma_start, m_satb_dma_start};
                if (expected_q.size() == 0) begin
                    $error("result word with none expected: %h", got);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.read_byte !== want.read_byte) begin
                        $error("read_byte: expected %0h, actual %0h", want.read_byte, got.read_byte);
                        mismatches++;
                    end
                    if (got.pending_now !== want.pending_now) begin
                        $error("pending_now: expected %0h, actual %0h",
                               want.pending_now, got.pending_now);
                        mismatches++;
                    end
                    if (got.vram_dma_start !== want.vram_dma_start) begin
                        $error("vram_dma_start: expected %0b, actual %0b",
                               want.vram_dma_start, got.vram_dma_start);
                        mismatches++;
                    end
                    if (got.satb_dma_start !== want.satb_dma_start) begin
                        $error("satb_dma_start: expected %0b, actual %0b",
                               want.satb_dma_start, got.satb_dma_start);
                        mismatches++;
                    end
                end
            end
        end
        backlog    <= expected_q.size();
        fail_count <= mismatches;
    end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives host reads, writes and flag raises into the video controller
// register port: a directed opening, then block transfers through video
// memory, register writes, flag traffic and noise, with random stalls on
// both channels until a quiet tail. A shadow of the address state keeps
// every memory fetch on a word that has been written.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import vcrp_pkg::*;

    localparam int unsigned TOTAL_WORDS = 1650;
    localparam int unsigned QUIET_FROM  = 1450;
    localparam int unsigned DRAIN_AT    = 800;
    localparam int unsigned HANG_LIMIT  = 500;
    localparam int unsigned TAIL_CYCLES = 10;

    localparam logic [1:0] OFF_STATUS_LO = 2'b00;
    localparam logic [1:0] OFF_STATUS_HI = 2'b01;
    localparam logic [1:0] OFF_DATA_LO   = 2'b10;
    localparam logic [1:0] OFF_DATA_HI   = 2'b11;
    localparam logic [4:0] SEL_UNUSED    = 5'h1F;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [1:0]  s_bus_offset;
    logic [7:0]  s_write_byte;
    logic [5:0]  s_raise_flags;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_read_byte;
    logic [5:0]  m_pending_now;
    logic        m_vram_dma_start;
    logic        m_satb_dma_start;
    int unsigned backlog;
    int unsigned fail_count;

    // address state as the port sees it, for stimulus shaping
    logic [4:0]  sh_sel;
    logic [15:0] sh_waddr;
    logic [15:0] sh_raddr;
    logic [7:0]  sh_step;
    bit          sh_filled [VIDEO_WORDS];

    int unsigned sent = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    bit          quiet = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    video_controller_register_port dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_bus_offset     (s_bus_offset),
        .s_write_byte     (s_write_byte),
        .s_raise_flags    (s_raise_flags),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_byte      (m_read_byte),
        .m_pending_now    (m_pending_now),
        .m_vram_dma_start (m_vram_dma_start),
        .m_satb_dma_start (m_satb_dma_start)
    );

    register_port_checker u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_bus_offset     (s_bus_offset),
        .s_write_byte     (s_write_byte),
        .s_raise_flags    (s_raise_flags),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_byte      (m_read_byte),
        .m_pending_now    (m_pending_now),
        .m_vram_dma_start (m_vram_dma_start),
        .m_satb_dma_start (m_satb_dma_start),
        .backlog          (backlog),
        .fail_count       (fail_count)
    );

    always @(posedge aclk) begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 7);
            m_ready    <= 1'b0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            stall_left <= 0;
            m_ready    <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("video_controller_register_port test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] sel_byte(logic [4:0] s);
        return {3'($urandom), s};
    endfunction

    task automatic put_word(opcode_t op, logic [1:0] off, logic [7:0] d, logic [5:0] f);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_bus_offset  <= off;
        s_write_byte  <= d;
        s_raise_flags <= f;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (op == OP_WRITE && off == OFF_STATUS_LO) begin
            sh_sel = d[4:0];
        end else if (op == OP_WRITE && off[1]) begin
            case (sh_sel)
                SEL_MAWR: sh_waddr = off[0] ? {d, sh_waddr[7:0]} : {sh_waddr[15:8], d};
                SEL_MARR: sh_raddr = off[0] ? {d, sh_raddr[7:0]} : {sh_raddr[15:8], d};
                SEL_VRW: begin
                    if (off == OFF_DATA_HI) begin
                        sh_filled[sh_waddr % VIDEO_WORDS] = 1'b1;
                        sh_waddr += sh_step;
                    end
                end
                SEL_CR: begin
                    if (off == OFF_DATA_HI)
                        sh_step = (d[4:3] == 2'd0) ? 8'h01 : 8'h20 << (d[4:3] - 2'd1);
                end
                default: ;
            endcase
        end else if (op == OP_READ && off == OFF_DATA_HI && sh_sel == SEL_VRW) begin
            sh_raddr += sh_step;
        end
    endtask

    // write one word of memory, then put the register select back
    task automatic fill_word(logic [15:0] addr);
        logic [4:0] keep;
        keep = sh_sel;
        put_word(OP_WRITE, OFF_STATUS_LO, sel_byte(SEL_MAWR), 6'($urandom));
        put_word(OP_WRITE, OFF_DATA_LO, addr[7:0], 6'($urandom));
        put_word(OP_WRITE, OFF_DATA_HI, addr[15:8], 6'($urandom));
        put_word(OP_WRITE, OFF_STATUS_LO, sel_byte(SEL_VRW), 6'($urandom));
        put_word(OP_WRITE, OFF_DATA_LO, 8'($urandom), 6'($urandom));
        put_word(OP_WRITE, OFF_DATA_HI, 8'($urandom), 6'($urandom));
        put_word(OP_WRITE, OFF_STATUS_LO, sel_byte(keep), 6'($urandom));
    endtask

    task automatic host_access(opcode_t op, logic [1:0] off, logic [7:0] d, logic [5:0] f);
        logic [15:0] fetch_at;
        bit          fetches;
        fetches  = 1'b0;
        fetch_at = '0;
        if (op == OP_WRITE && off[1] && sh_sel == SEL_MARR) begin
            fetches  = 1'b1;
            fetch_at = off[0] ? {d, sh_raddr[7:0]} : {sh_raddr[15:8], d};
        end else if (op == OP_READ && off == OFF_DATA_HI && sh_sel == SEL_VRW) begin
            fetches  = 1'b1;
            fetch_at = sh_raddr + sh_step;
        end
        if (fetches && !sh_filled[fetch_at % VIDEO_WORDS]) fill_word(fetch_at);
        put_word(op, off, d, f);
    endtask

    task automatic write_reg(logic [4:0] s, logic [7:0] lo, logic [7:0] hi);
        host_access(OP_WRITE, OFF_STATUS_LO, sel_byte(s), 6'($urandom));
        host_access(OP_WRITE, OFF_DATA_LO, lo, 6'($urandom));
        host_access(OP_WRITE, OFF_DATA_HI, hi, 6'($urandom));
    endtask

    initial begin
        logic [15:0] base;
        logic [4:0]  s;
        int unsigned n;
        int unsigned kind;
        bit          drained;
        drained       = 1'b0;
        sh_sel        = '0;
        sh_waddr      = '0;
        sh_raddr      = '0;
        sh_step       = 8'h01;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_opcode      <= '0;
        s_bus_offset  <= '0;
        s_write_byte  <= '0;
        s_raise_flags <= '0;
        m_ready       <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        host_access(OP_NONE, OFF_DATA_HI, 8'hFF, 6'h3F);
        host_access(OP_READ, OFF_STATUS_LO, 8'h00, 6'h00);
        host_access(OP_RAISE, OFF_STATUS_LO, 8'h00, 6'h3F);
        host_access(OP_READ, OFF_STATUS_HI, 8'h00, 6'h00);
        host_access(OP_READ, OFF_STATUS_LO, 8'h00, 6'h00);
        host_access(OP_WRITE, OFF_STATUS_HI, 8'hFF, 6'h00);
        host_access(OP_READ, OFF_DATA_LO, 8'h00, 6'h00);
        host_access(OP_READ, OFF_DATA_HI, 8'h00, 6'h00);
        write_reg(SEL_UNUSED, 8'hAA, 8'h55);
        write_reg(SEL_LENR, 8'hFF, 8'h00);
        write_reg(SEL_DVSSR, 8'h00, 8'hFF);
        write_reg(SEL_CR, 8'hFF, 8'hFF);
        write_reg(SEL_MAWR, 8'hFF, 8'hFF);
        write_reg(SEL_VRW, 8'h00, 8'hFF);
        write_reg(SEL_MARR, 8'hFF, 8'hFF);
        host_access(OP_WRITE, OFF_STATUS_LO, sel_byte(SEL_VRW), 6'h00);
        host_access(OP_READ, OFF_DATA_LO, 8'h00, 6'h00);
        host_access(OP_READ, OFF_DATA_HI, 8'h00, 6'h00);
        host_access(OP_RAISE, OFF_DATA_LO, 8'h00, 6'h15);
        host_access(OP_RAISE, OFF_DATA_HI, 8'h00, 6'h2A);
        host_access(OP_READ, OFF_STATUS_LO, 8'h00, 6'h00);

        while (sent < TOTAL_WORDS) begin
            if (sent >= QUIET_FROM) quiet = 1'b1;
            if (!drained && sent >= DRAIN_AT) begin
                drained = 1'b1;
                s_valid <= 1'b0;
                do @(posedge aclk); while (backlog != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                // block transfer: write n+1 words, read back n of them
                n = $urandom_range(1, 6);
                if ($urandom_range(0, 2) == 0) write_reg(SEL_CR, 8'($urandom), 8'($urandom));
                base = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                                   : 16'($urandom);
                write_reg(SEL_MAWR, base[7:0], base[15:8]);
                host_access(OP_WRITE, OFF_STATUS_LO, sel_byte(SEL_VRW), 6'($urandom));
                repeat (n + 1) begin
                    host_access(OP_WRITE, OFF_DATA_LO, 8'($urandom), 6'($urandom));
                    host_access(OP_WRITE, OFF_DATA_HI, 8'($urandom), 6'($urandom));
                end
                write_reg(SEL_MARR, base[7:0], base[15:8]);
                host_access(OP_WRITE, OFF_STATUS_LO, sel_byte(SEL_VRW), 6'($urandom));
                repeat (n) begin
                    if ($urandom_range(0, 3) != 0)
                        host_access(OP_READ, OFF_DATA_LO, 8'($urandom), 6'($urandom));
                    host_access(OP_READ, OFF_DATA_HI, 8'($urandom), 6'($urandom));
                end
            end else if (kind < 6) begin
                s = 5'($urandom);
                host_access(OP_WRITE, OFF_STATUS_LO, sel_byte(s), 6'($urandom));
                if ($urandom_range(0, 2) != 0)
                    host_access(OP_WRITE, OFF_DATA_LO, 8'($urandom), 6'($urandom));
                if ($urandom_range(0, 2) != 0)
                    host_access(OP_WRITE, OFF_DATA_HI, 8'($urandom), 6'($urandom));
            end else if (kind < 8) begin
                host_access(OP_RAISE, 2'($urandom), 8'($urandom), 6'($urandom));
                host_access(OP_READ, ($urandom_range(0, 3) == 0) ? OFF_STATUS_HI : OFF_STATUS_LO,
                            8'($urandom), 6'($urandom));
            end else begin
                repeat ($urandom_range(1, 4))
                    host_access(opcode_t'(2'($urandom)), 2'($urandom), 8'($urandom),
                                6'($urandom));
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (backlog != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("video_controller_register_port test passed");
        else
            $display("video_controller_register_port test failed");
        $finish;
    end

endmodule
